/* src/nsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types and constants of the nearest-segment search block.
// ----------------------------------------------------------------------------
package nsp_pkg;

   // item action codes
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   localparam int COORD_W = 16;
   localparam int INDEX_W = 6;
   localparam int REQ_W   = 72;   // 66 bits of fields, padded to bytes
   localparam int RSP_W   = 72;   // 71 bits of fields, padded to bytes

   // one stored segment
   typedef struct packed {
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_x;
   } seg_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_point;   // capture query point
      logic rd_issue;     // start a store read
      logic geo_a;        // deltas from read data
      logic geo_b;        // products for len and dot
      logic geo_c;        // sums, clamp decisions
      logic div_start;    // start the fraction division
      logic div_step;     // one quotient bit
      logic cp_a;         // closest point products
      logic cp_b;         // error terms
      logic cp_c;         // error squares
      logic cp_d;         // distance sum and compare
      logic best_clear;   // reset running best
      logic best_fetch;   // read best entry for result
      logic best_load;    // latch best entry
   } nsp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_needed;   // t lies strictly between 0 and 1
   } nsp_sts_type;

endpackage

/* src/nsp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_datapath
// Segment memory, projection arithmetic, bit-serial divider and best tracker.
// ----------------------------------------------------------------------------
module nsp_datapath #(
   parameter int MAX_SEGMENTS = 64,
   parameter int IDX_W        = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [IDX_W-1:0]                   wr_addr,
   input  nsp_pkg::seg_type                   wr_data,
   input  logic [IDX_W-1:0]                   rd_addr,
   input  logic signed [nsp_pkg::COORD_W-1:0] point_x,
   input  logic signed [nsp_pkg::COORD_W-1:0] point_y,
   input  nsp_pkg::nsp_cmd_type               cmd,
   output nsp_pkg::nsp_sts_type               sts,
   output logic [IDX_W-1:0]                   best_idx,
   output nsp_pkg::seg_type                   best_seg
);

   // segment memory, registered read
   nsp_pkg::seg_type mem [MAX_SEGMENTS];
   nsp_pkg::seg_type rd_ff;
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_issue || cmd.best_fetch) begin
         rd_ff <= mem[rd_addr];
      end
   end

   logic signed [15:0] px_ff, py_ff;
   logic signed [16:0] dx_ff, dy_ff, qx_ff, qy_ff;
   logic signed [15:0] ax_ff, ay_ff;
   logic signed [33:0] pxx_ff, pyy_ff, pdx_ff, pdy_ff;
   logic [34:0]        len_ff;
   logic signed [35:0] dot_ff;
   logic [16:0]        t_ff;
   logic               dneed_ff;
   logic [50:0]        rem_ff;
   logic [15:0]        quo_ff;
   logic [4:0]         cnt_ff;
   logic signed [34:0] mx_ff, my_ff;
   logic signed [19:0] ex_ff, ey_ff;
   logic [39:0]        sx_ff, sy_ff;
   logic [40:0]        bd_ff;
   logic               bvalid_ff;
   logic [IDX_W-1:0]   cur_ff, bidx_ff;
   nsp_pkg::seg_type   bseg_ff;

   // division trial subtract
   logic [51:0] rem_sh;
   logic [51:0] rem_try;
   assign rem_sh  = {rem_ff, quo_ff[15]};
   assign rem_try = rem_sh - {17'd0, len_ff};

   logic [40:0] dist_sum;
   assign dist_sum = {1'b0, sx_ff} + {1'b0, sy_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_point) begin
         px_ff <= point_x;
         py_ff <= point_y;
      end
      // deltas
      if (cmd.geo_a) begin
         ax_ff <= rd_ff.start_x;
         ay_ff <= rd_ff.start_y;
         dx_ff <= 17'(rd_ff.end_x) - 17'(rd_ff.start_x);
         dy_ff <= 17'(rd_ff.end_y) - 17'(rd_ff.start_y);
         qx_ff <= 17'(px_ff) - 17'(rd_ff.start_x);
         qy_ff <= 17'(py_ff) - 17'(rd_ff.start_y);
      end
      // products
      if (cmd.geo_b) begin
         pxx_ff <= dx_ff * dx_ff;
         pyy_ff <= dy_ff * dy_ff;
         pdx_ff <= qx_ff * dx_ff;
         pdy_ff <= qy_ff * dy_ff;
      end
      // sums and clamp
      if (cmd.geo_c) begin
         logic [34:0]        l;
         logic signed [35:0] d;
         l = 35'(pxx_ff) + 35'(pyy_ff);
         d = 36'(pdx_ff) + 36'(pdy_ff);
         len_ff <= l;
         dot_ff <= d;
         dneed_ff <= 1'b0;
         if (l == 35'd0 || d <= 36'sd0) begin
            t_ff <= 17'd0;
         end else if (d >= $signed({1'b0, l})) begin
            t_ff <= 17'h10000;
         end else begin
            t_ff <= 17'd0;
            dneed_ff <= 1'b1;
         end
      end
      // restoring division of dot<<16 by len, one bit a step
      if (cmd.div_start) begin
         rem_ff <= {15'd0, dot_ff};
         quo_ff <= 16'd0;
         cnt_ff <= 5'd0;
      end else if (cmd.div_step) begin
         // dot < len, so 16 steps shifting in zeros give the whole quotient
         if (!rem_try[51]) begin
            rem_ff <= rem_try[50:0];
            quo_ff <= {quo_ff[14:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[50:0];
            quo_ff <= {quo_ff[14:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            t_ff <= {1'b0, quo_ff[14:0], ~rem_try[51]};
         end
      end
      // closest point
      if (cmd.cp_a) begin
         mx_ff <= 35'(dx_ff) * 35'($signed({1'b0, t_ff}));
         my_ff <= 35'(dy_ff) * 35'($signed({1'b0, t_ff}));
      end
      if (cmd.cp_b) begin
         ex_ff <= 20'(qx_ff) - 20'(mx_ff >>> 16);
         ey_ff <= 20'(qy_ff) - 20'(my_ff >>> 16);
      end
      if (cmd.cp_c) begin
         sx_ff <= 40'(ex_ff) * 40'(ex_ff);
         sy_ff <= 40'(ey_ff) * 40'(ey_ff);
      end
      if (cmd.best_load) begin
         bseg_ff <= rd_ff;
      end
   end

   // running best, first index wins ties
   always_ff @(posedge clock) begin
      if (reset || cmd.best_clear) begin
         bvalid_ff <= 1'b0;
         cur_ff    <= '0;
         bidx_ff   <= '0;
      end else if (cmd.cp_d) begin
         if (!bvalid_ff || dist_sum < bd_ff) begin
            bd_ff   <= dist_sum;
            bidx_ff <= cur_ff;
         end
         bvalid_ff <= 1'b1;
         cur_ff    <= cur_ff + 1'b1;
      end
   end

   assign sts.div_needed = dneed_ff;
   assign best_idx = bidx_ff;
   assign best_seg = bseg_ff;

endmodule

/* src/nsp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_ctrl
// Sequencer: table count, per-segment step order and result handshake.
// ----------------------------------------------------------------------------
module nsp_ctrl #(
   parameter int MAX_SEGMENTS = 64,
   parameter int IDX_W        = 6,
   parameter int CNT_W        = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_action,
   output logic                 req_ready,
   output logic                 wr_en,
   output logic [IDX_W-1:0]     wr_addr,
   output logic [IDX_W-1:0]     rd_addr,
   input  logic [IDX_W-1:0]     best_idx,
   output nsp_pkg::nsp_cmd_type cmd,
   input  nsp_pkg::nsp_sts_type sts,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_found
);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_GA, S_GB, S_GC, S_DIV, S_CA, S_CB, S_CC, S_CD,
      S_FETCH, S_LOAD, S_OUT
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] seg_ff;
   logic [5:0]       step_ff;
   logic             found_ff;
   logic             accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && req_action == nsp_pkg::ACT_APPEND
                      && count_ff < CNT_W'(MAX_SEGMENTS);
   assign wr_addr   = count_ff[IDX_W-1:0];
   assign rd_addr   = (state_ff == S_FETCH) ? best_idx : seg_ff[IDX_W-1:0];
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_found = found_ff;

   // command decode
   always_comb begin
      cmd = '0;
      cmd.load_point = accept;
      cmd.best_clear = accept;
      case (state_ff)
         S_READ:  cmd.rd_issue   = 1'b1;
         S_GA:    cmd.geo_a      = 1'b1;
         S_GB:    cmd.geo_b      = 1'b1;
         S_GC:    cmd.geo_c      = 1'b1;
         S_DIV: begin
            cmd.div_start = (step_ff == 6'd0);
            cmd.div_step  = (step_ff != 6'd0);
         end
         S_CA:    cmd.cp_a       = 1'b1;
         S_CB:    cmd.cp_b       = 1'b1;
         S_CC:    cmd.cp_c       = 1'b1;
         S_CD:    cmd.cp_d       = 1'b1;
         S_FETCH: cmd.best_fetch = 1'b1;
         S_LOAD:  cmd.best_load  = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         seg_ff   <= '0;
         step_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (accept) begin
               seg_ff <= '0;
               case (req_action)
                  nsp_pkg::ACT_CLEAR: count_ff <= '0;
                  nsp_pkg::ACT_APPEND:
                     if (wr_en) count_ff <= count_ff + 1'b1;
                  nsp_pkg::ACT_QUERY: begin
                     found_ff <= (count_ff != '0);
                     state_ff <= (count_ff != '0) ? S_READ : S_OUT;
                  end
                  default: ;
               endcase
            end
            S_READ: state_ff <= S_GA;
            S_GA:   state_ff <= S_GB;
            S_GB:   state_ff <= S_GC;
            S_GC: begin
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            // a load step, then 16 quotient bits when a division is needed
            S_DIV: begin
               if (!sts.div_needed || step_ff == 6'd16) begin
                  state_ff <= S_CA;
               end
               step_ff <= step_ff + 6'd1;
            end
            S_CA: state_ff <= S_CB;
            S_CB: state_ff <= S_CC;
            S_CC: state_ff <= S_CD;
            S_CD: begin
               seg_ff   <= seg_ff + 1'b1;
               state_ff <= (seg_ff + 1'b1 == count_ff) ? S_FETCH : S_READ;
            end
            S_FETCH: state_ff <= S_LOAD;
            S_LOAD:  state_ff <= S_OUT;
            S_OUT:   if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* src/nearest_segment_to_point.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_segment_to_point
// Keeps a table of 2D segments and finds the one nearest a query point.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one transaction per item: clear, append or query.
//   Clear and append give no response.
//   A query gives one rsp_ transaction: found, index and segment endpoints.
//   A query walks the stored segments one at a time; each passes the read,
//   geometry, bit-serial divider and closest-point steps, and the quotient
//   steps are skipped when t is clamped. The response follows the last
//   segment, and the next item is taken only after the response. An empty
//   table answers without a walk.
//   req_tready is low from query accept until the response is taken.
//   A stalled rsp_ side holds the response; the block waits.
//   Reset empties the table; stored entries are left as they were.
// ----------------------------------------------------------------------------
module nearest_segment_to_point #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action[1:0], point_x/start_x[17:2], point_y/start_y[33:18], end_x[49:34], end_y[65:50]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // found[0], best_index[6:1], best_start_x[22:7], best_start_y[38:23],
   // best_end_x[54:39], best_end_y[70:55]
   output logic [71:0] rsp_tdata
);

   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

   nsp_pkg::nsp_cmd_type cmd;
   nsp_pkg::nsp_sts_type sts;
   logic                 wr_en, found;
   logic [IDX_W-1:0]     wr_addr, rd_addr, best_idx;
   nsp_pkg::seg_type     wr_data, best_seg;
   logic [5:0]           idx6;

   assign wr_data = nsp_pkg::seg_type'({req_tdata[65:50], req_tdata[49:34],
                                        req_tdata[33:18], req_tdata[17:2]});

   nsp_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
      .clock, .reset,
      .req_valid(req_tvalid), .req_action(req_tdata[1:0]), .req_ready(req_tready),
      .wr_en, .wr_addr, .rd_addr, .best_idx, .cmd, .sts,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_found(found)
   );

   nsp_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS), .IDX_W(IDX_W)) u_dp (
      .clock, .reset, .wr_en, .wr_addr, .wr_data, .rd_addr,
      .point_x(req_tdata[17:2]), .point_y(req_tdata[33:18]),
      .cmd, .sts, .best_idx, .best_seg
   );

   assign idx6 = 6'({{6{1'b0}}, best_idx});

   // empty table reports all zero
   assign rsp_tdata = found ? {1'b0, best_seg.end_y, best_seg.end_x,
                               best_seg.start_y, best_seg.start_x, idx6, 1'b1}
                            : 72'd0;

   // response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
   // no new item while a response waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready during response");

endmodule
